### design/wapc_pkg.sv
// Shared types, constants and helpers for the windowed accuracy-per-cost core.
package wapc_pkg;

  localparam int WindowMax = 256;
  localparam int PtrW      = $clog2(WindowMax);
  localparam int CntW      = PtrW + 1;
  localparam int ElemW     = 16;
  localparam int AccW      = 24;
  localparam int TotW      = 25;
  localparam int RingW     = 1 + 2 * ElemW;
  localparam int DivNumW   = 33;
  localparam int DivDenW   = TotW;
  localparam int DivSteps  = DivNumW;
  localparam int StepW     = $clog2(DivSteps + 1);
  localparam int MetricW   = 32;
  localparam int RatioW    = 17;

  localparam logic [1:0] LABEL_NONE   = 2'd0;
  localparam logic [1:0] LABEL_FIRST  = 2'd1;
  localparam logic [1:0] LABEL_SECOND = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV_EFF,
    ST_WAIT_EFF,
    ST_DIV_ENE,
    ST_WAIT_ENE,
    ST_DIV_RAT,
    ST_WAIT_RAT,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic                      start;
    logic [DivNumW-1:0]        dividend;
    logic [DivDenW-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                      done;
    logic [DivNumW-1:0]        quotient;
  } div_rsp_t;

  // Add one element to a running sum, clamping to the signed accumulator range.
  function automatic logic signed [AccW-1:0] sat_acc(input logic signed [AccW-1:0] acc,
                                                     input logic signed [ElemW-1:0] elem);
    logic signed [AccW:0] sum;
    sum = {acc[AccW-1], acc} + {{(AccW+1-ElemW){elem[ElemW-1]}}, elem};
    if (sum[AccW] != sum[AccW-1]) begin
      sat_acc = sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      sat_acc = sum[AccW-1:0];
    end
  endfunction

endpackage

### design/wapc_ring.sv
// Window history memory: one write port, one read port with registered data.
module wapc_ring (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [wapc_pkg::PtrW-1:0]         wr_addr,
  input  logic [wapc_pkg::RingW-1:0]        wr_data,
  input  logic                              rd_en,
  input  logic [wapc_pkg::PtrW-1:0]         rd_addr,
  output logic [wapc_pkg::RingW-1:0]        rd_data
);

  logic [wapc_pkg::RingW-1:0] mem [wapc_pkg::WindowMax];
  logic [wapc_pkg::RingW-1:0] rd_data_r;

  // Write the newest entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read the oldest entry; registered data appears in the cycle after rd_en
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/wapc_div.sv
// Shared restoring divider: one quotient bit per cycle.
module wapc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  wapc_pkg::div_req_t req,
  output wapc_pkg::div_rsp_t rsp
);

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [wapc_pkg::StepW-1:0]          cnt_r, cnt_nxt;
  logic [wapc_pkg::DivDenW-1:0]        rem_r, rem_nxt;
  logic [wapc_pkg::DivDenW-1:0]        den_r, den_nxt;
  logic [wapc_pkg::DivNumW-1:0]        quo_r, quo_nxt;
  logic [wapc_pkg::DivDenW:0]          partial;
  logic [wapc_pkg::DivDenW:0]          diff;

  // Shift in the next dividend bit and try one subtract
  always_comb begin
    partial  = {rem_r, quo_r[wapc_pkg::DivNumW-1]};
    diff     = partial - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (busy_r) begin
      quo_nxt = {quo_r[wapc_pkg::DivNumW-2:0], ~diff[wapc_pkg::DivDenW]};
      rem_nxt = diff[wapc_pkg::DivDenW] ? partial[wapc_pkg::DivDenW-1:0]
                                        : diff[wapc_pkg::DivDenW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == wapc_pkg::StepW'(wapc_pkg::DivSteps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

### design/windowed_accuracy_per_cost_core.sv
// Top level: score accumulation, window bookkeeping and division sequencer.
//
// Usage: element transactions arrive on the in_ channel (in_valid/in_stall).
// Each one adds in_elem_a and in_elem_b into two saturating 24-bit sums.
// A transaction with in_last_elem set closes the vector: the block predicts
// a label, scores it against in_label, pushes the correct flag, effort and
// energy into the sliding window and produces one out_ transaction.
// Non-last transactions are taken one per cycle. After a last transaction
// in_stall stays high through one window update, three 33-step divisions
// through a single shared bit-serial divider (effort metric, energy metric,
// correct ratio) and one output load.
// The result sits in an output register; a new vector may be taken while
// it waits, but the next result is held back until out_stall drops.
// cfg_wr_en/cfg_wr_data set the window length (clamped to 1..256) and clear
// the window; write only while the block is idle.
// Reset (rst_n low, synchronous) empties the window, clears the sums,
// drops out_valid and sets the window length to 16.
module windowed_accuracy_per_cost_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [8:0]                          cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [15:0]                  in_elem_a,
  input  logic signed [15:0]                  in_elem_b,
  input  logic                                in_last_elem,
  input  logic [1:0]                          in_label,
  input  logic signed [15:0]                  in_effort,
  input  logic signed [15:0]                  in_energy,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [31:0]                         out_metric_effort,
  output logic [31:0]                         out_metric_energy,
  output logic [16:0]                         out_correct_ratio,
  output logic                                out_was_correct
);

  localparam int PtrW = wapc_pkg::PtrW;
  localparam int CntW = wapc_pkg::CntW;
  localparam int AccW = wapc_pkg::AccW;
  localparam int TotW = wapc_pkg::TotW;
  localparam int EW   = wapc_pkg::ElemW;

  wapc_pkg::state_t            state_r, state_nxt;
  logic signed [AccW-1:0]      acc_a_r, acc_a_nxt;
  logic signed [AccW-1:0]      acc_b_r, acc_b_nxt;
  logic [PtrW-1:0]             wp_r, wp_nxt;
  logic [CntW-1:0]             fill_r, fill_nxt;
  logic [CntW-1:0]             wlen_r, wlen_nxt;
  logic [CntW-1:0]             ctot_r, ctot_nxt;
  logic signed [TotW-1:0]      etot_r, etot_nxt;
  logic signed [TotW-1:0]      ntot_r, ntot_nxt;
  logic                        evict_r, evict_nxt;
  logic                        ok_r, ok_nxt;
  logic signed [EW-1:0]        eff_r, eff_nxt;
  logic signed [EW-1:0]        ene_r, ene_nxt;
  logic [31:0]                 res_eff_r, res_eff_nxt;
  logic [31:0]                 res_ene_r, res_ene_nxt;
  logic [16:0]                 res_rat_r, res_rat_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [31:0]                 out_eff_r, out_eff_nxt;
  logic [31:0]                 out_ene_r, out_ene_nxt;
  logic [16:0]                 out_rat_r, out_rat_nxt;
  logic                        out_ok_r, out_ok_nxt;

  logic                        in_acc;
  logic                        out_acc;
  logic signed [AccW-1:0]      sum_a;
  logic signed [AccW-1:0]      sum_b;
  logic [1:0]                  pred;
  logic [CntW-1:0]             cfg_len;
  logic                        ring_wr_en;
  logic                        ring_rd_en;
  logic [PtrW-1:0]             ring_rd_addr;
  logic [wapc_pkg::RingW-1:0]  ring_rd_data;
  logic                        old_flag;
  logic signed [EW-1:0]        old_eff;
  logic signed [EW-1:0]        old_ene;
  wapc_pkg::div_req_t          div_req;
  wapc_pkg::div_rsp_t          div_rsp;
  logic                        tot_pos;
  logic [31:0]                 metric_q;

  // Take input only while idle
  assign in_stall = (state_r != wapc_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;

  // Running sums and the label decision for the incoming element
  always_comb begin
    sum_a = wapc_pkg::sat_acc(acc_a_r, in_elem_a);
    sum_b = wapc_pkg::sat_acc(acc_b_r, in_elem_b);
    if (sum_a > sum_b) begin
      pred = wapc_pkg::LABEL_FIRST;
    end else if (sum_a < sum_b) begin
      pred = wapc_pkg::LABEL_SECOND;
    end else begin
      pred = wapc_pkg::LABEL_NONE;
    end
  end

  // Clamp the configured window length into 1..WindowMax
  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_len = CntW'(1);
    end else if (cfg_wr_data > CntW'(wapc_pkg::WindowMax)) begin
      cfg_len = CntW'(wapc_pkg::WindowMax);
    end else begin
      cfg_len = cfg_wr_data;
    end
  end

  // Oldest entry sits fill_count slots behind the write pointer
  assign ring_rd_en   = (state_r == wapc_pkg::ST_IDLE) && in_acc && in_last_elem;
  assign ring_rd_addr = wp_r - fill_r[PtrW-1:0];
  assign ring_wr_en   = (state_r == wapc_pkg::ST_UPDATE);
  assign {old_flag, old_eff, old_ene} = ring_rd_data;

  wapc_ring u_ring (
    .clk     (clk),
    .wr_en   (ring_wr_en),
    .wr_addr (wp_r),
    .wr_data ({ok_r, eff_r, ene_r}),
    .rd_en   (ring_rd_en),
    .rd_addr (ring_rd_addr),
    .rd_data (ring_rd_data)
  );

  // Select operands for the shared divider
  always_comb begin
    div_req = '0;
    unique case (state_r)
      wapc_pkg::ST_DIV_EFF: begin
        div_req.start    = 1'b1;
        div_req.dividend = {ctot_r, 24'd0};
        div_req.divisor  = etot_r;
      end
      wapc_pkg::ST_DIV_ENE: begin
        div_req.start    = 1'b1;
        div_req.dividend = {ctot_r, 24'd0};
        div_req.divisor  = ntot_r;
      end
      wapc_pkg::ST_DIV_RAT: begin
        div_req.start    = 1'b1;
        div_req.dividend = {8'd0, ctot_r, 16'd0};
        div_req.divisor  = {{(TotW-CntW){1'b0}}, wlen_r};
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  wapc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Saturate a metric quotient; a non-positive total gives zero
  always_comb begin
    if (state_r == wapc_pkg::ST_WAIT_EFF) begin
      tot_pos = !etot_r[TotW-1] && (etot_r != '0);
    end else begin
      tot_pos = !ntot_r[TotW-1] && (ntot_r != '0);
    end
    if (!tot_pos) begin
      metric_q = '0;
    end else if (div_rsp.quotient[32]) begin
      metric_q = '1;
    end else begin
      metric_q = div_rsp.quotient[31:0];
    end
  end

  // Sequencer: next state and register updates
  always_comb begin
    state_nxt     = state_r;
    acc_a_nxt     = acc_a_r;
    acc_b_nxt     = acc_b_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    wlen_nxt      = wlen_r;
    ctot_nxt      = ctot_r;
    etot_nxt      = etot_r;
    ntot_nxt      = ntot_r;
    evict_nxt     = evict_r;
    ok_nxt        = ok_r;
    eff_nxt       = eff_r;
    ene_nxt       = ene_r;
    res_eff_nxt   = res_eff_r;
    res_ene_nxt   = res_ene_r;
    res_rat_nxt   = res_rat_r;
    out_valid_nxt = out_acc ? 1'b0 : out_valid_r;
    out_eff_nxt   = out_eff_r;
    out_ene_nxt   = out_ene_r;
    out_rat_nxt   = out_rat_r;
    out_ok_nxt    = out_ok_r;

    unique case (state_r)
      wapc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_last_elem) begin
            acc_a_nxt = '0;
            acc_b_nxt = '0;
            ok_nxt    = (in_label != wapc_pkg::LABEL_NONE) && (pred == in_label);
            eff_nxt   = in_effort;
            ene_nxt   = in_energy;
            evict_nxt = (fill_r >= wlen_r);
            state_nxt = wapc_pkg::ST_UPDATE;
          end else begin
            acc_a_nxt = sum_a;
            acc_b_nxt = sum_b;
          end
        end
      end
      wapc_pkg::ST_UPDATE: begin
        // Drop the oldest entry if full, then add the newest
        if (evict_r) begin
          ctot_nxt = ctot_r - CntW'(old_flag) + CntW'(ok_r);
          etot_nxt = etot_r - TotW'(old_eff) + TotW'(eff_r);
          ntot_nxt = ntot_r - TotW'(old_ene) + TotW'(ene_r);
        end else begin
          ctot_nxt = ctot_r + CntW'(ok_r);
          etot_nxt = etot_r + TotW'(eff_r);
          ntot_nxt = ntot_r + TotW'(ene_r);
          fill_nxt = fill_r + 1'b1;
        end
        wp_nxt    = wp_r + 1'b1;
        state_nxt = wapc_pkg::ST_DIV_EFF;
      end
      wapc_pkg::ST_DIV_EFF: begin
        state_nxt = wapc_pkg::ST_WAIT_EFF;
      end
      wapc_pkg::ST_WAIT_EFF: begin
        if (div_rsp.done) begin
          res_eff_nxt = metric_q;
          state_nxt   = wapc_pkg::ST_DIV_ENE;
        end
      end
      wapc_pkg::ST_DIV_ENE: begin
        state_nxt = wapc_pkg::ST_WAIT_ENE;
      end
      wapc_pkg::ST_WAIT_ENE: begin
        if (div_rsp.done) begin
          res_ene_nxt = metric_q;
          state_nxt   = wapc_pkg::ST_DIV_RAT;
        end
      end
      wapc_pkg::ST_DIV_RAT: begin
        state_nxt = wapc_pkg::ST_WAIT_RAT;
      end
      wapc_pkg::ST_WAIT_RAT: begin
        if (div_rsp.done) begin
          res_rat_nxt = div_rsp.quotient[16:0];
          state_nxt   = wapc_pkg::ST_LOAD;
        end
      end
      wapc_pkg::ST_LOAD: begin
        // Hold until the output register is free
        if (!out_valid_r || out_acc) begin
          out_valid_nxt = 1'b1;
          out_eff_nxt   = res_eff_r;
          out_ene_nxt   = res_ene_r;
          out_rat_nxt   = res_rat_r;
          out_ok_nxt    = ok_r;
          state_nxt     = wapc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wapc_pkg::ST_IDLE;
      end
    endcase

    // Window length write clears the window
    if (cfg_wr_en) begin
      wlen_nxt = cfg_len;
      wp_nxt   = '0;
      fill_nxt = '0;
      ctot_nxt = '0;
      etot_nxt = '0;
      ntot_nxt = '0;
    end
  end

  // Control and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wapc_pkg::ST_IDLE;
      acc_a_r     <= '0;
      acc_b_r     <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      wlen_r      <= CntW'(16);
      ctot_r      <= '0;
      etot_r      <= '0;
      ntot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_a_r     <= acc_a_nxt;
      acc_b_r     <= acc_b_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      wlen_r      <= wlen_nxt;
      ctot_r      <= ctot_nxt;
      etot_r      <= etot_nxt;
      ntot_r      <= ntot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    evict_r   <= evict_nxt;
    ok_r      <= ok_nxt;
    eff_r     <= eff_nxt;
    ene_r     <= ene_nxt;
    res_eff_r <= res_eff_nxt;
    res_ene_r <= res_ene_nxt;
    res_rat_r <= res_rat_nxt;
    out_eff_r <= out_eff_nxt;
    out_ene_r <= out_ene_nxt;
    out_rat_r <= out_rat_nxt;
    out_ok_r  <= out_ok_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_metric_effort = out_eff_r;
  assign out_metric_energy = out_ene_r;
  assign out_correct_ratio = out_rat_r;
  assign out_was_correct   = out_ok_r;

endmodule

### design/wapc_checker.sv
// Port-level checks for the windowed accuracy-per-cost core, with bind.
module wapc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last_elem,
  input logic        out_valid,
  input logic        out_stall,
  input logic [16:0] out_correct_ratio,
  input logic        out_was_correct
);

  // A closed vector blocks input while the divisions run
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_elem) |=> in_stall)
    else $error("input taken right after a last element");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  // Correct ratio never exceeds one
  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_correct_ratio <= 17'd65536))
    else $error("correct ratio above one");

  // A correct decision leaves a nonzero count in the window
  a_ratio_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_was_correct) |-> (out_correct_ratio != 17'd0))
    else $error("correct decision with zero ratio");

endmodule

bind windowed_accuracy_per_cost_core wapc_checker u_wapc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_last_elem      (in_last_elem),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_correct_ratio (out_correct_ratio),
  .out_was_correct   (out_was_correct)
);

### tb/tb_top.sv
// Self-checking testbench for the windowed accuracy-per-cost core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          DRAIN_CYCLES = 150;
  localparam int          PRINT_CAP    = 200;
  localparam longint      METRIC_CAP   = 64'h0000_0000_FFFF_FFFF;
  localparam int          ACC_HIGH     = 8388607;
  localparam int          ACC_LOW      = -8388608;

  typedef struct {
    logic signed [15:0] elem_a;
    logic signed [15:0] elem_b;
    logic               last_elem;
    logic [1:0]         label;
    logic signed [15:0] effort;
    logic signed [15:0] energy;
  } elem_t;

  typedef struct {
    logic [31:0] metric_effort;
    logic [31:0] metric_energy;
    logic [16:0] correct_ratio;
    logic        was_correct;
  } result_t;

  typedef enum int {VEC_WIDE, VEC_NARROW, VEC_CLIMB, VEC_DIVE} vec_shape_t;

  // Tracks the score sums and the decision window, and holds the results still owed.
  class meter_scoreboard;
    int      errors;
    result_t owed_results[$];
    int      sum_a;
    int      sum_b;
    bit      flag_ring[wapc_pkg::WindowMax];
    int      effort_ring[wapc_pkg::WindowMax];
    int      energy_ring[wapc_pkg::WindowMax];
    int      wr_ptr;
    int      fill;
    int      correct_total;
    longint  effort_total;
    longint  energy_total;
    int      window_len;

    function new();
      window_len = 16;
    endfunction

    function void clear_window();
      wr_ptr = 0;
      fill = 0;
      correct_total = 0;
      effort_total = 0;
      energy_total = 0;
    endfunction

    // Clamp the written length into 1..WindowMax and empty the window.
    function void set_window(logic [8:0] value);
      int v;
      v = value;
      if (v < 1) v = 1;
      if (v > wapc_pkg::WindowMax) v = wapc_pkg::WindowMax;
      window_len = v;
      clear_window();
    endfunction

    function int clamp_sum(int sum);
      if (sum > ACC_HIGH) return ACC_HIGH;
      if (sum < ACC_LOW) return ACC_LOW;
      return sum;
    endfunction

    // Correct count over a Q8.8 total, as unsigned Q16.16.
    function logic [31:0] cost_metric(longint total);
      longint q;
      if (total <= 0) return 32'd0;
      q = (longint'(correct_total) << 24) / total;
      if (q > METRIC_CAP) return 32'hFFFF_FFFF;
      return q[31:0];
    endfunction

    function void record_transaction(elem_t item);
      logic [1:0] guess;
      bit         ok;
      int         oldest;
      result_t    want;
      sum_a = clamp_sum(sum_a + item.elem_a);
      sum_b = clamp_sum(sum_b + item.elem_b);
      if (!item.last_elem) return;
      guess = wapc_pkg::LABEL_NONE;
      if (sum_a > sum_b) guess = wapc_pkg::LABEL_FIRST;
      else if (sum_a < sum_b) guess = wapc_pkg::LABEL_SECOND;
      ok = (item.label != wapc_pkg::LABEL_NONE) && (guess == item.label);
      sum_a = 0;
      sum_b = 0;
      // Drop the oldest decision once the window is full.
      if (fill >= window_len) begin
        oldest = (wr_ptr + wapc_pkg::WindowMax - fill) % wapc_pkg::WindowMax;
        correct_total -= flag_ring[oldest];
        effort_total -= effort_ring[oldest];
        energy_total -= energy_ring[oldest];
        fill--;
      end
      flag_ring[wr_ptr] = ok;
      effort_ring[wr_ptr] = item.effort;
      energy_ring[wr_ptr] = item.energy;
      correct_total += ok;
      effort_total += item.effort;
      energy_total += item.energy;
      fill++;
      wr_ptr = (wr_ptr + 1) % wapc_pkg::WindowMax;
      want.metric_effort = cost_metric(effort_total);
      want.metric_energy = cost_metric(energy_total);
      want.correct_ratio = 17'((correct_total << 16) / window_len);
      want.was_correct = ok;
      owed_results.insert(owed_results.size(), want);
    endfunction

    // Print one line per mismatch (capped), always count it.
    task report(string msg);
      if (errors < PRINT_CAP) $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        report("result transaction with no decision outstanding");
        return;
      end
      want = owed_results[0];
      owed_results.delete(0);
      if (got.metric_effort !== want.metric_effort)
        report($sformatf("metric_effort got %h expected %h",
                         got.metric_effort, want.metric_effort));
      if (got.metric_energy !== want.metric_energy)
        report($sformatf("metric_energy got %h expected %h",
                         got.metric_energy, want.metric_energy));
      if (got.correct_ratio !== want.correct_ratio)
        report($sformatf("correct_ratio got %h expected %h",
                         got.correct_ratio, want.correct_ratio));
      if (got.was_correct !== want.was_correct)
        report($sformatf("was_correct got %b expected %b",
                         got.was_correct, want.was_correct));
    endtask

    task close_out();
      if (owed_results.size() != 0)
        report($sformatf("%0d results never arrived", owed_results.size()));
    endtask

    function int owed();
      return owed_results.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n         = 1'b0;
  logic               cfg_wr_en     = 1'b0;
  logic [8:0]         cfg_wr_data   = '0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_elem_a     = '0;
  logic signed [15:0] in_elem_b     = '0;
  logic               in_last_elem  = 1'b0;
  logic [1:0]         in_label      = wapc_pkg::LABEL_NONE;
  logic signed [15:0] in_effort     = '0;
  logic signed [15:0] in_energy     = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [31:0]        out_metric_effort;
  logic [31:0]        out_metric_energy;
  logic [16:0]        out_correct_ratio;
  logic               out_was_correct;

  meter_scoreboard board;
  int              send_idle_pct;
  int              recv_stall_pct;
  int unsigned     cycle_count;

  windowed_accuracy_per_cost_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_elem_a         (in_elem_a),
    .in_elem_b         (in_elem_b),
    .in_last_elem      (in_last_elem),
    .in_label          (in_label),
    .in_effort         (in_effort),
    .in_energy         (in_energy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_metric_effort (out_metric_effort),
    .out_metric_energy (out_metric_energy),
    .out_correct_ratio (out_correct_ratio),
    .out_was_correct   (out_was_correct)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stall the result channel at random, one decision per falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Check every result transaction against the oldest expectation.
  always @(posedge clk) begin : watch_results
    result_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.metric_effort = out_metric_effort;
      seen.metric_energy = out_metric_energy;
      seen.correct_ratio = out_correct_ratio;
      seen.was_correct = out_was_correct;
      board.check_result(seen);
    end
  end

  // Give up on a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Present one element transaction, idling at random first; hold until accepted.
  task automatic send_elem(input elem_t item);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_elem_a <= item.elem_a;
    in_elem_b <= item.elem_b;
    in_last_elem <= item.last_elem;
    in_label <= item.label;
    in_effort <= item.effort;
    in_energy <= item.energy;
    do @(posedge clk); while (in_stall);
    board.record_transaction(item);
  endtask

  task automatic send_fields(input logic signed [15:0] a, input logic signed [15:0] b,
                             input logic last, input logic [1:0] label,
                             input logic signed [15:0] effort,
                             input logic signed [15:0] energy);
    elem_t item;
    item.elem_a = a;
    item.elem_b = b;
    item.last_elem = last;
    item.label = label;
    item.effort = effort;
    item.energy = energy;
    send_elem(item);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.owed() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [8:0] value);
    drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    board.set_window(value);
  endtask

  function automatic logic signed [15:0] pick_cost();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1, 2:    return 16'($urandom_range(0, 600));
      default: return 16'($urandom_range(0, 128)) - 16'd64;
    endcase
  endfunction

  // Send one score vector; the climb and dive shapes drive a sum into its clamp.
  task automatic send_vector(input int len, input vec_shape_t shape);
    elem_t item;
    int    k;
    int    sa;
    int    sb;
    sa = 0;
    sb = 0;
    for (k = 0; k < len; k++) begin
      case (shape)
        VEC_WIDE: begin
          item.elem_a = 16'($urandom);
          item.elem_b = 16'($urandom);
        end
        VEC_NARROW: begin
          item.elem_a = 16'($urandom_range(0, 6)) - 16'd3;
          item.elem_b = 16'($urandom_range(0, 6)) - 16'd3;
        end
        VEC_CLIMB: begin
          item.elem_a = (k < len - 8) ? 16'sh7FFF : 16'sh8000;
          item.elem_b = (k < 250) ? 16'sh7FFF : 16'sh0000;
        end
        default: begin
          item.elem_a = (k < len - 8) ? 16'sh8000 : 16'sh7FFF;
          item.elem_b = (k < 250) ? 16'sh8000 : 16'sh0000;
        end
      endcase
      sa += item.elem_a;
      sb += item.elem_b;
      item.last_elem = (k == len - 1);
      if (!item.last_elem) begin
        item.label = 2'($urandom);
        item.effort = 16'($urandom);
        item.energy = 16'($urandom);
      end else begin
        if (shape == VEC_CLIMB || shape == VEC_DIVE) begin
          item.label = 2'($urandom_range(1, 2));
        end else if ($urandom_range(0, 1) == 1) begin
          item.label = (sa > sb) ? wapc_pkg::LABEL_FIRST :
                       (sa < sb) ? wapc_pkg::LABEL_SECOND : wapc_pkg::LABEL_NONE;
        end else begin
          item.label = 2'($urandom);
        end
        item.effort = pick_cost();
        item.energy = pick_cost();
      end
      send_elem(item);
    end
  endtask

  // Mostly short vectors, some longer, with wide or near-equal scores.
  task automatic run_mixed(input int budget);
    int         sent;
    int         len;
    vec_shape_t shape;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 12);
      shape = ($urandom_range(0, 2) == 0) ? VEC_NARROW : VEC_WIDE;
      send_vector(len, shape);
      sent += len;
    end
  endtask

  // Fill a full-size window with correct decisions at near-zero cost, then wrap it.
  task automatic run_full_window(input int decisions);
    elem_t item;
    int    i;
    for (i = 0; i < decisions; i++) begin
      item.elem_a = 16'($urandom);
      item.elem_b = 16'($urandom);
      if (item.elem_b == item.elem_a) item.elem_b = ~item.elem_a;
      item.last_elem = 1'b1;
      if (i < wapc_pkg::WindowMax) begin
        item.label = (item.elem_a > item.elem_b) ? wapc_pkg::LABEL_FIRST
                                                 : wapc_pkg::LABEL_SECOND;
        item.effort = (i == 0) ? 16'sd1 : 16'sd0;
        item.energy = (i == 7) ? 16'sd1 : 16'sd0;
      end else begin
        item.label = 2'($urandom);
        item.effort = pick_cost();
        item.energy = pick_cost();
      end
      send_elem(item);
    end
  endtask

  task automatic run_directed();
    // Reset window length: extremes, ties, no label, the unused label, a wrong guess.
    send_fields(16'sh7FFF, 16'sh8000, 1'b1, wapc_pkg::LABEL_FIRST, 16'sh7FFF, 16'sh8000);
    send_fields(16'sh8000, 16'sh7FFF, 1'b1, wapc_pkg::LABEL_SECOND, 16'sh8000, 16'sh7FFF);
    send_fields(16'sh1234, 16'sh1234, 1'b1, wapc_pkg::LABEL_NONE, 16'sh0000, 16'sh0000);
    send_fields(16'sd5, 16'sd4, 1'b1, 2'd3, 16'sh0100, 16'sh0100);
    send_fields(16'sd5, 16'sd4, 1'b1, wapc_pkg::LABEL_SECOND, 16'sh0100, 16'sh0100);
    send_fields(-16'sd1, 16'sd0, 1'b1, wapc_pkg::LABEL_NONE, 16'sh0040, 16'sh0040);
    send_fields(16'sd100, 16'sd0, 1'b0, 2'd3, 16'shFFFF, 16'sh8000);
    send_fields(16'sd0, 16'sd50, 1'b1, wapc_pkg::LABEL_FIRST, 16'sh0100, 16'sh0080);
    send_fields(16'sh4000, 16'sh4000, 1'b1, wapc_pkg::LABEL_FIRST, 16'sh0010, 16'sh0020);
    send_fields(16'shFFFF, 16'shFFFE, 1'b1, wapc_pkg::LABEL_FIRST, 16'sh7FFF, 16'sh0001);
    // One-entry window: zero, tiny, huge and negative costs.
    write_window(9'd1);
    send_fields(16'sd2, 16'sd1, 1'b1, wapc_pkg::LABEL_FIRST, 16'sd0, 16'sd0);
    send_fields(16'sd2, 16'sd1, 1'b1, wapc_pkg::LABEL_FIRST, 16'sd1, 16'sd1);
    send_fields(16'sd1, 16'sd2, 1'b1, wapc_pkg::LABEL_SECOND, 16'sh7FFF, 16'sh7FFF);
    send_fields(16'sd1, 16'sd2, 1'b1, wapc_pkg::LABEL_SECOND, 16'sh8000, 16'shFFFF);
    send_fields(16'sd1, 16'sd2, 1'b1, wapc_pkg::LABEL_FIRST, 16'sd1, 16'sd1);
    send_fields(16'sh8000, 16'sh7FFF, 1'b0, wapc_pkg::LABEL_NONE, 16'sd0, 16'sd0);
    send_fields(16'sh7FFF, 16'sh8000, 1'b1, wapc_pkg::LABEL_NONE, 16'sd3, 16'sd3);
  endtask

  initial begin
    board = new();
    set_idling(25, 77);
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    write_window(9'd1);
    run_mixed(25);
    write_window(9'd0);
    send_vector(272, VEC_CLIMB);
    run_mixed(25);
    set_idling(77, 25);
    write_window(9'd256);
    run_full_window(270);
    write_window(9'($urandom_range(2, 255)));
    run_mixed(25);
    send_vector(272, VEC_DIVE);
    set_idling(0, 0);
    write_window(9'h1FF);
    run_mixed(25);
    write_window(9'($urandom_range(1, 20)));
    run_mixed(25);
    drain();
    board.close_out();
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
design/wapc_pkg.sv
design/wapc_ring.sv
design/wapc_div.sv
design/windowed_accuracy_per_cost_core.sv
design/wapc_checker.sv
tb/tb_top.sv
